// ===== hdl/hsvrgb_pkg.sv =====
package hsvrgb_pkg;

    // Field formats
    localparam int HUE_W          = 16;
    localparam int CHAN_W         = 13;
    localparam int RGB_W          = 8;
    localparam int HUE_FRAC_BITS  = 6;
    localparam int CHAN_FRAC_BITS = 12;

    // Fixed-point constants: ONE is 1.0, S60 is 60 degrees, CIRCLE is 360 degrees
    localparam int ONE    = 1 << CHAN_FRAC_BITS;
    localparam int S60    = 60 << HUE_FRAC_BITS;
    localparam int CIRCLE = 360 << HUE_FRAC_BITS;

    // Wrapped hue and remainder within a sector
    localparam int HW_W  = $clog2(CIRCLE);
    localparam int REM_W = $clog2(S60);

    // Hue wrap: whole circles that a 16-bit hue can be away from [0,360)
    localparam int MAX_WRAP = (1 << (HUE_W - 1)) / CIRCLE + 1;
    localparam int CAND_W   = $clog2((1 << (HUE_W - 1)) + MAX_WRAP * CIRCLE) + 1;

    // Channel term ONE*S60 - s*k, and its product with v
    localparam int FULL   = ONE * S60;
    localparam int FULL_W = $clog2(FULL + 1);
    localparam int NUM_W  = CHAN_W + FULL_W;

    // 255 / 15 = 17 and the denominator ONE*ONE*S60 = 15 * 2^RND_SHIFT
    localparam int RND_SHIFT = 2 * CHAN_FRAC_BITS + HUE_FRAC_BITS + 2;
    localparam int SUM_W     = NUM_W + 5;
    localparam int RGB_MAX   = (1 << RGB_W) - 1;

    // 60-degree sectors in HSV order
    localparam int NUM_SECTORS = 6;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

endpackage

// ===== hdl/hsv_to_rgb_converter_core.sv =====
// HSV to RGB color converter, 8 bits per channel.
// Request channel: drive i_hue (signed degrees, 6 fractional bits), i_saturation
// and i_brightness (12 fractional bits, 4096 = 1.0) and raise start; the request
// is taken at every rising edge with start high and busy low. busy stays low,
// so a new request can enter on every clock.
// Result channel: o_red, o_green and o_blue are valid for exactly one cycle
// while o_strobe is high; the receiver must take them then, it cannot stall.
// Throughput is one pixel per clock. The six register stages are: hue
// wrap, sector split, saturation-by-remainder multiply, channel term select,
// value multiply, scale-and-round to 8 bits.
// Hue of any value wraps into [0,360); saturation and brightness above 1.0
// clamp to 1.0. Synchronous active-low reset clears the stage valid bits, so
// no strobe comes out for requests in flight at reset.
module hsv_to_rgb_converter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [hsvrgb_pkg::HUE_W-1:0]   i_hue,
    input  logic [hsvrgb_pkg::CHAN_W-1:0]  i_saturation,
    input  logic [hsvrgb_pkg::CHAN_W-1:0]  i_brightness,
    output logic                           o_strobe,
    output logic [hsvrgb_pkg::RGB_W-1:0]   o_red,
    output logic [hsvrgb_pkg::RGB_W-1:0]   o_green,
    output logic [hsvrgb_pkg::RGB_W-1:0]   o_blue
);
    import hsvrgb_pkg::*;

    localparam int LATENCY = 6;

    logic [LATENCY-1:0]  r_valid;
    logic [LATENCY-1:0]  n_valid;

    logic [CHAN_W-1:0]   n_s1;
    logic [CHAN_W-1:0]   n_v1;
    logic [CHAN_W-1:0]   r_s1;
    logic [CHAN_W-1:0]   r_v1;
    logic [CHAN_W-1:0]   r_s2;
    logic [CHAN_W-1:0]   r_v2;
    t_sector             sector2;
    logic [REM_W-1:0]    rem2;
    t_sector             r_sector3;
    logic [CHAN_W-1:0]   r_v3;
    logic [FULL_W-1:0]   r_sr3;
    logic [FULL_W-1:0]   r_sfull3;
    logic [FULL_W-1:0]   xv;
    logic [FULL_W-1:0]   xp;
    logic [FULL_W-1:0]   xq;
    logic [FULL_W-1:0]   xt;
    logic [FULL_W-1:0]   n_xr4;
    logic [FULL_W-1:0]   n_xg4;
    logic [FULL_W-1:0]   n_xb4;
    logic [FULL_W-1:0]   r_xr4;
    logic [FULL_W-1:0]   r_xg4;
    logic [FULL_W-1:0]   r_xb4;
    logic [CHAN_W-1:0]   r_v4;

    // Never hold off a request
    assign busy = 1'b0;

    // Advance the valid bits with the data
    always_comb begin
        n_valid = {r_valid[LATENCY-2:0], start & ~busy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Stage 1: clamp saturation and value to 1.0
    always_comb begin
        n_s1 = (i_saturation > CHAN_W'(ONE)) ? CHAN_W'(ONE) : i_saturation;
        n_v1 = (i_brightness > CHAN_W'(ONE)) ? CHAN_W'(ONE) : i_brightness;
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        r_v1 <= n_v1;
    end

    // Stages 1-2: hue wrap and sector split
    hsvrgb_hue u_hue (
        .i_clk    (i_clk),
        .i_hue    (i_hue),
        .o_sector (sector2),
        .o_rem    (rem2)
    );

    always_ff @(posedge i_clk) begin
        r_s2 <= r_s1;
        r_v2 <= r_v1;
    end

    // Stage 3: saturation times remainder and times a full sector
    always_ff @(posedge i_clk) begin
        r_sr3     <= FULL_W'(r_s2) * FULL_W'(rem2);
        r_sfull3  <= FULL_W'(r_s2 * S60);
        r_sector3 <= sector2;
        r_v3      <= r_v2;
    end

    // Stage 4: form the four channel terms and pick them by sector
    always_comb begin
        xv = FULL_W'(FULL);
        xp = FULL_W'(FULL) - r_sfull3;
        xq = FULL_W'(FULL) - r_sr3;
        xt = xp + r_sr3;
        case (r_sector3)
            SEC_RED: begin
                n_xr4 = xv; n_xg4 = xt; n_xb4 = xp;
            end
            SEC_YELLOW: begin
                n_xr4 = xq; n_xg4 = xv; n_xb4 = xp;
            end
            SEC_GREEN: begin
                n_xr4 = xp; n_xg4 = xv; n_xb4 = xt;
            end
            SEC_CYAN: begin
                n_xr4 = xp; n_xg4 = xq; n_xb4 = xv;
            end
            SEC_BLUE: begin
                n_xr4 = xt; n_xg4 = xp; n_xb4 = xv;
            end
            default: begin
                n_xr4 = xv; n_xg4 = xp; n_xb4 = xq;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_xr4 <= n_xr4;
        r_xg4 <= n_xg4;
        r_xb4 <= n_xb4;
        r_v4  <= r_v3;
    end

    // Stages 5-6: multiply by value, scale to 8 bits
    hsvrgb_scale u_scale_red (
        .i_clk  (i_clk),
        .i_v    (r_v4),
        .i_x    (r_xr4),
        .o_chan (o_red)
    );

    hsvrgb_scale u_scale_green (
        .i_clk  (i_clk),
        .i_v    (r_v4),
        .i_x    (r_xg4),
        .o_chan (o_green)
    );

    hsvrgb_scale u_scale_blue (
        .i_clk  (i_clk),
        .i_v    (r_v4),
        .i_x    (r_xb4),
        .o_chan (o_blue)
    );

    assign o_strobe = r_valid[LATENCY-1];

`ifndef SYNTHESIS
    a_strobe_follows_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##6 o_strobe)
        else $error("request did not produce a result after the pipeline latency");

    a_no_spurious_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##6 !o_strobe)
        else $error("result strobe without a matching request");

    a_gray_when_unsaturated : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_saturation == '0) |-> ##6 (o_red == o_green && o_green == o_blue))
        else $error("zero saturation did not give equal channels");

    a_black_when_dark : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_brightness == '0) |-> ##6 (o_red == '0 && o_green == '0 && o_blue == '0))
        else $error("zero brightness did not give black");
`endif

endmodule

// ===== hdl/hsvrgb_hue.sv =====
module hsvrgb_hue (
    input  logic                          i_clk,
    input  logic [hsvrgb_pkg::HUE_W-1:0]  i_hue,
    output hsvrgb_pkg::t_sector           o_sector,
    output logic [hsvrgb_pkg::REM_W-1:0]  o_rem
);
    import hsvrgb_pkg::*;

    logic signed [CAND_W-1:0] h_ext;
    logic signed [CAND_W-1:0] cand;
    logic [HW_W-1:0]          n_hw;
    logic [HW_W-1:0]          r_hw;
    t_sector                  n_sector;
    logic [HW_W-1:0]          base;
    logic [REM_W-1:0]         n_rem;
    t_sector                  r_sector;
    logic [REM_W-1:0]         r_rem;

    // Wrap the hue into one circle: try each whole-circle offset in parallel
    always_comb begin
        h_ext = CAND_W'($signed(i_hue));
        cand  = '0;
        n_hw  = '0;
        for (int k = -MAX_WRAP; k <= MAX_WRAP; k++) begin
            cand = h_ext + CAND_W'(k * CIRCLE);
            if (cand >= 0 && cand < CAND_W'(CIRCLE)) begin
                n_hw = HW_W'(cand);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hw <= n_hw;
    end

    // Split into sector and remainder by comparing against each sector start
    always_comb begin
        n_sector = SEC_RED;
        base     = '0;
        for (int k = 1; k < NUM_SECTORS; k++) begin
            if (r_hw >= HW_W'(k * S60)) begin
                n_sector = t_sector'(k);
                base     = HW_W'(k * S60);
            end
        end
        n_rem = REM_W'(r_hw - base);
    end

    always_ff @(posedge i_clk) begin
        r_sector <= n_sector;
        r_rem    <= n_rem;
    end

    assign o_sector = r_sector;
    assign o_rem    = r_rem;

endmodule

// ===== hdl/hsvrgb_scale.sv =====
module hsvrgb_scale (
    input  logic                           i_clk,
    input  logic [hsvrgb_pkg::CHAN_W-1:0]  i_v,
    input  logic [hsvrgb_pkg::FULL_W-1:0]  i_x,
    output logic [hsvrgb_pkg::RGB_W-1:0]   o_chan
);
    import hsvrgb_pkg::*;

    logic [NUM_W-1:0]           r_num;
    logic [SUM_W-1:0]           half;
    logic [SUM_W-1:0]           sum;
    logic [SUM_W-RND_SHIFT-1:0] upper;
    logic [RGB_W-1:0]           n_chan;
    logic [RGB_W-1:0]           r_chan;

    // Multiply value by the channel term
    always_ff @(posedge i_clk) begin
        r_num <= NUM_W'(i_v) * NUM_W'(i_x);
    end

    // Scale by 17 and round half up at the binary point, saturate to 8 bits
    always_comb begin
        half  = SUM_W'(1) << (RND_SHIFT - 1);
        sum   = (SUM_W'(r_num) << 4) + SUM_W'(r_num) + half;
        upper = sum[SUM_W-1:RND_SHIFT];
        if (upper > (SUM_W-RND_SHIFT)'(RGB_MAX)) begin
            n_chan = RGB_W'(RGB_MAX);
        end else begin
            n_chan = RGB_W'(upper);
        end
    end

    always_ff @(posedge i_clk) begin
        r_chan <= n_chan;
    end

    assign o_chan = r_chan;

endmodule
